>>> rtl/lbl_pkg.sv
`timescale 1ns / 1ps

package lbl_pkg;

	// Default width of the byte position and run length counters.
	localparam int OFFSET_BITS_DEF = 16;

	// Entries in the queue between the classifier and the token builder.
	localparam int QUEUE_DEPTH = 4;

	// Character classes. A pending run is held with the class of its bytes.
	typedef enum logic [1:0] {
		CLS_SKIP   = 2'd0,
		CLS_ALPHA  = 2'd1,
		CLS_DIGIT  = 2'd2,
		CLS_SINGLE = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		TK_OP     = 3'd0,
		TK_OPEN   = 3'd1,
		TK_CLOSE  = 3'd2,
		TK_SYMBOL = 3'd3,
		TK_NUMBER = 3'd4,
		TK_BADNUM = 3'd5,
		TK_END    = 3'd6
	} tok_kind_t;

	// What the classifier hands on for one byte.
	typedef struct packed {
		cls_t      cls;
		tok_kind_t kind;
		logic [3:0] digit;
		logic       fin;
	} char_info_t;

	// One finished token as it leaves the block.
	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] value;
	} token_t;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	function automatic char_info_t classify(input logic [7:0] c, input logic fin);
		char_info_t r;
		r.cls   = CLS_SKIP;
		r.kind  = TK_OP;
		r.digit = c[3:0];
		r.fin   = fin;
		if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
			r.cls = CLS_ALPHA;
		end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			r.cls = CLS_DIGIT;
		end else if (c == CH_MINUS || c == CH_PLUS || c == CH_STAR || c == CH_BANG) begin
			r.cls = CLS_SINGLE;
		end else if (c == CH_OPEN) begin
			r.cls  = CLS_SINGLE;
			r.kind = TK_OPEN;
		end else if (c == CH_CLOSE) begin
			r.cls  = CLS_SINGLE;
			r.kind = TK_CLOSE;
		end
		return r;
	endfunction

endpackage

>>> rtl/lbl_front.sv
`timescale 1ns / 1ps

module lbl_front #(
	parameter int OFFSET_BITS = lbl_pkg::OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,
	input  logic s_tlast,
	input  logic q_full,
	output logic q_push,
	output logic [OFFSET_BITS+$bits(lbl_pkg::char_info_t)-1:0] q_entry
);
	import lbl_pkg::*;

	logic [OFFSET_BITS-1:0] byte_pos_q;
	char_info_t             info;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign info     = classify(s_tdata, s_tlast);
	assign q_entry  = {byte_pos_q, info};

	// The position restarts at zero after the final byte of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
		end else if (q_push) begin
			if (s_tlast) begin
				byte_pos_q <= '0;
			end else begin
				byte_pos_q <= byte_pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

>>> rtl/lbl_fifo.sv
`timescale 1ns / 1ps

module lbl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lbl_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output logic [WIDTH-1:0] head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + {{(PW-1){1'b0}}, 1'b1};
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + {{(PW-1){1'b0}}, 1'b1};
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (do_pop && !do_push) begin
				count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

>>> rtl/lbl_back.sv
`timescale 1ns / 1ps

module lbl_back #(
	parameter int OFFSET_BITS = lbl_pkg::OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  logic [OFFSET_BITS+$bits(lbl_pkg::char_info_t)-1:0] head_entry,
	output logic pop,
	output logic m_tvalid,
	input  logic m_tready,
	output lbl_pkg::token_t m_tok,
	output logic m_last
);
	import lbl_pkg::*;

	localparam int OB = OFFSET_BITS;

	// Run state.
	cls_t          run_mode_q;
	logic [OB-1:0] run_start_q;
	logic [OB-1:0] run_len_q;
	logic [30:0]   acc_q;
	logic          ovf_q;
	logic [15:0]   tok_cnt_q;

	// Results already delivered for the entry at the head of the queue.
	logic [2:0]    done_q;

	logic          out_valid_q;
	token_t        out_tok_q;
	logic          out_last_q;

	logic [OB-1:0] e_pos;
	char_info_t    e_info;
	logic [OB-1:0] end_pos;

	logic          a_hit, b_hit, c_hit, is_run, new_run, b_flush;
	cls_t          mode0, n_mode;
	logic [OB-1:0] n_start, n_len;
	logic [30:0]   acc_base, n_acc;
	logic          ovf_base, n_ovf;
	logic [34:0]   prod;
	logic [15:0]   cnt_sum;
	token_t        tok_a, tok_b, tok_c, tok_sel;
	logic [2:0]    remain, pick;
	logic          last_pick, out_free, out_load, consume;

	assign {e_pos, e_info} = head_entry;
	assign end_pos         = e_pos + {{(OB-1){1'b0}}, 1'b1};

	// A run pending under another class closes before this byte is looked at.
	assign a_hit   = (run_mode_q != CLS_SKIP) && (run_mode_q != e_info.cls);
	assign is_run  = (e_info.cls == CLS_ALPHA) || (e_info.cls == CLS_DIGIT);
	assign mode0   = a_hit ? CLS_SKIP : run_mode_q;
	assign new_run = is_run && (mode0 == CLS_SKIP);
	assign n_mode  = is_run ? e_info.cls : mode0;

	always_comb begin
		n_start  = new_run ? e_pos : run_start_q;
		if (!is_run) begin
			n_len = '0;
		end else if (new_run) begin
			n_len = {{(OB-1){1'b0}}, 1'b1};
		end else if (run_len_q != {OB{1'b1}}) begin
			n_len = run_len_q + {{(OB-1){1'b0}}, 1'b1};
		end else begin
			n_len = run_len_q;
		end
		acc_base = new_run ? '0 : acc_q;
		ovf_base = new_run ? 1'b0 : ovf_q;
		// Times ten as eight plus two, then the new digit.
		prod = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} + {31'd0, e_info.digit};
		n_acc = acc_base;
		n_ovf = ovf_base;
		if (e_info.cls == CLS_DIGIT && !ovf_base) begin
			if (prod[34:31] != 4'd0) begin
				n_ovf = 1'b1;
			end else begin
				n_acc = prod[30:0];
			end
		end
	end

	assign b_flush = e_info.fin && (n_mode != CLS_SKIP);
	assign b_hit   = (e_info.cls == CLS_SINGLE) || b_flush;
	assign c_hit   = e_info.fin;
	assign cnt_sum = tok_cnt_q + 16'(a_hit) + 16'(b_hit);

	always_comb begin
		tok_a.kind  = (run_mode_q == CLS_ALPHA) ? TK_SYMBOL : (ovf_q ? TK_BADNUM : TK_NUMBER);
		tok_a.start = 16'(run_start_q);
		tok_a.len   = 16'(run_len_q);
		tok_a.value = (tok_a.kind == TK_NUMBER) ? acc_q : '0;

		if (e_info.cls == CLS_SINGLE) begin
			tok_b.kind  = e_info.kind;
			tok_b.start = 16'(e_pos);
			tok_b.len   = 16'd1;
			tok_b.value = '0;
		end else begin
			tok_b.kind  = (n_mode == CLS_ALPHA) ? TK_SYMBOL : (n_ovf ? TK_BADNUM : TK_NUMBER);
			tok_b.start = 16'(n_start);
			tok_b.len   = 16'(n_len);
			tok_b.value = (tok_b.kind == TK_NUMBER) ? n_acc : '0;
		end

		tok_c.kind  = TK_END;
		tok_c.start = 16'(end_pos);
		tok_c.len   = '0;
		tok_c.value = 31'(cnt_sum);
	end

	// Results go out in order: closed run, single-byte token or run flushed at the final byte, end of string.
	assign remain    = {c_hit, b_hit, a_hit} & ~done_q;
	assign pick      = remain & (~remain + 3'd1);
	assign last_pick = ((remain & ~pick) == 3'b000);

	always_comb begin
		unique case (pick)
			3'b001:  tok_sel = tok_a;
			3'b010:  tok_sel = tok_b;
			3'b100:  tok_sel = tok_c;
			default: tok_sel = tok_c;
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign out_load = head_valid && out_free && (remain != 3'b000);
	assign consume  = head_valid && ((remain == 3'b000) || (out_load && last_pick));
	assign pop      = consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q  <= CLS_SKIP;
			run_start_q <= '0;
			run_len_q   <= '0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			tok_cnt_q   <= '0;
			done_q      <= '0;
		end else if (consume) begin
			done_q <= '0;
			if (b_flush) begin
				run_mode_q <= CLS_SKIP;
				run_len_q  <= '0;
				acc_q      <= '0;
				ovf_q      <= 1'b0;
			end else begin
				run_mode_q <= n_mode;
				run_len_q  <= n_len;
				acc_q      <= n_acc;
				ovf_q      <= n_ovf;
			end
			run_start_q <= n_start;
			tok_cnt_q   <= e_info.fin ? 16'd0 : cnt_sum;
		end else if (out_load) begin
			done_q <= done_q | pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tok_q  <= tok_sel;
			out_last_q <= last_pick;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tok    = out_tok_q;
	assign m_last   = out_last_q;

`ifndef SYNTHESIS
	a_mode_never_single: assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q != CLS_SINGLE)
		else $error("run held under the single-byte class");

	a_idle_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(run_mode_q == CLS_SKIP) |-> (run_len_q == '0))
		else $error("run length left over with no run pending");

	a_end_never_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done_q[2] == 1'b0)
		else $error("entry kept after its end item went out");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_tok_q.kind == TK_END) |-> out_last_q)
		else $error("end item not flagged as last of its byte");
`endif

endmodule

>>> rtl/lisp_byte_lexer_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                  Contents
// s_*      in         tvalid tready tdata      tdata[7:0] char_byte
//                     tlast                    final_byte
// m_*      out        tvalid tready tdata      tdata[15:0] start_offset, [31:16] token_length,
//                     tuser tlast              [62:32] number_value; tuser token_kind;
//                                              tlast run_last
//
// A byte is classified and queued in the cycle it is taken; the token builder turns it into
// its results one per cycle while the output accepts them, as it has a single output port.
// The asynchronous reset clears the run state, the byte position, the token count and the
// queue. No clearing pass follows it.
// A stall at the output backs up the queue, and the input stalls only once the queue is full.

module lisp_byte_lexer_unit #(
	parameter int OFFSET_BITS = lbl_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // start_offset, token_length, number_value, zero pad
	output logic [2:0]  m_tuser,   // token_kind
	output logic        m_tlast    // run_last
);
	import lbl_pkg::*;

	// Queue entry: byte position above the classified byte.
	localparam int ENTRY_W = OFFSET_BITS + $bits(char_info_t);

	logic               q_push;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_in;
	logic [ENTRY_W-1:0] q_head;
	token_t             tok;

	// The classifier keeps the byte position and sorts each byte into its class.
	lbl_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	// A short queue lets the classifier run on while the builder emits several tokens.
	lbl_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_data (q_head)
	);

	// The builder holds the pending run, accumulates number values and emits tokens.
	lbl_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_entry (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tok      (tok),
		.m_last     (m_tlast)
	);

	assign m_tdata = {1'b0, tok.value, tok.len, tok.start};
	assign m_tuser = tok.kind;

endmodule
